>>> rtl/mdcu_pkg.sv
// ----------------------------------------------------------------------------
// Masked diffusion cell update: shared definitions
// Widths, register indexes, reset values and the structs that move between
// the pipeline sections of the cell update block.
// ----------------------------------------------------------------------------
`default_nettype none

package mdcu_pkg;

   // Field widths.
   localparam int VALUE_W   = 32;   // Q-format concentration, age and bounds
   localparam int COEF_W    = 31;   // unsigned coefficient registers
   localparam int MASK_W    = 6;    // one bit per neighbour
   localparam int NB_COUNT  = 6;
   localparam int DIFF_W    = VALUE_W + 1;   // one neighbour difference
   localparam int PAIR_W    = DIFF_W + 1;    // sum of two differences
   localparam int SUM_W     = PAIR_W + 2;    // sum of all six differences
   localparam int LO_W      = 32;   // low slice of a multiplicand
   localparam int MAG_W     = 62;   // magnitude of a clipped stage value
   localparam int STAGE_W   = MAG_W + 1;     // signed stage value

   // Largest magnitude a stage value may hold.
   localparam logic signed [STAGE_W-1:0] STAGE_MAX = {1'b0, {MAG_W{1'b1}}};

   // Configuration port.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFUSION_COEFF = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPACING_SQ  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_RATE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LOW      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HIGH     = 3'd5;

   // Register reset values.
   localparam logic [COEF_W-1:0] STEP_TIME_RST       = 31'd65;
   localparam logic [COEF_W-1:0] DIFFUSION_COEFF_RST = 31'd65536;
   localparam logic [COEF_W-1:0] INV_SPACING_SQ_RST  = 31'd65536;
   localparam logic [COEF_W-1:0] DECAY_RATE_RST      = 31'd0;
   localparam logic signed [VALUE_W-1:0] WINDOW_LOW_RST  = 32'sd0;
   localparam logic signed [VALUE_W-1:0] WINDOW_HIGH_RST = 32'sd0;

   // One input item.
   typedef struct packed {
      logic signed [VALUE_W-1:0] centre_value;
      logic signed [VALUE_W-1:0] west_value;
      logic signed [VALUE_W-1:0] east_value;
      logic signed [VALUE_W-1:0] south_value;
      logic signed [VALUE_W-1:0] north_value;
      logic signed [VALUE_W-1:0] below_value;
      logic signed [VALUE_W-1:0] above_value;
      logic [MASK_W-1:0]         neighbour_mask;
      logic                      cornified;
      logic signed [VALUE_W-1:0] cell_age;
   } item_type;

   // Output of the stencil front end.
   typedef struct packed {
      logic signed [SUM_W-1:0]   sum;
      logic signed [VALUE_W-1:0] centre;
      logic                      src;
   } front_type;

   // Carried alongside the diffusion multiplications.
   typedef struct packed {
      logic signed [STAGE_W-1:0] decay;
      logic signed [VALUE_W-1:0] centre;
      logic                      src;
      logic                      clip;
   } diff_side_type;

   // Carried alongside the time step multiplication.
   typedef struct packed {
      logic signed [VALUE_W-1:0] centre;
      logic                      clip;
   } step_side_type;

endpackage

`default_nettype wire

>>> rtl/mdcu_if.sv
// ----------------------------------------------------------------------------
// Masked diffusion cell update: channel interfaces
// Valid/ready channels for cell items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Cell item channel.
interface mdcu_req_if import mdcu_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] centre_value;
   logic signed [VALUE_W-1:0] west_value;
   logic signed [VALUE_W-1:0] east_value;
   logic signed [VALUE_W-1:0] south_value;
   logic signed [VALUE_W-1:0] north_value;
   logic signed [VALUE_W-1:0] below_value;
   logic signed [VALUE_W-1:0] above_value;
   logic [MASK_W-1:0]         neighbour_mask;
   logic                      cornified;
   logic signed [VALUE_W-1:0] cell_age;

   modport source (
      output valid, centre_value, west_value, east_value, south_value,
             north_value, below_value, above_value, neighbour_mask,
             cornified, cell_age,
      input  ready
   );
   modport sink (
      input  valid, centre_value, west_value, east_value, south_value,
             north_value, below_value, above_value, neighbour_mask,
             cornified, cell_age,
      output ready
   );
endinterface

// Result channel.
interface mdcu_rsp_if import mdcu_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] new_value;
   logic                      saturated;

   modport source (output valid, new_value, saturated, input ready);
   modport sink (input valid, new_value, saturated, output ready);
endinterface

// Register write channel.
interface mdcu_csr_if import mdcu_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/mdcu_front.sv
// ----------------------------------------------------------------------------
// Masked diffusion cell update: stencil front end
// Three stages: masked neighbour differences and the age window test, then
// pairwise sums, then the full Laplacian sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mdcu_front import mdcu_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire item_type                  in_item,
   input  wire logic signed [VALUE_W-1:0] win_low,
   input  wire logic signed [VALUE_W-1:0] win_high,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output front_type                      out_data
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   logic signed [VALUE_W-1:0] nb [NB_COUNT];
   logic signed [DIFF_W-1:0]  diff_in [NB_COUNT];
   logic signed [DIFF_W-1:0]  diff_ff [NB_COUNT];
   logic                      src_in;
   logic                      src1_ff, src2_ff, src3_ff;
   logic signed [VALUE_W-1:0] c1_ff, c2_ff, c3_ff;
   logic signed [PAIR_W-1:0]  pair_in [NB_COUNT/2];
   logic signed [PAIR_W-1:0]  pair_ff [NB_COUNT/2];
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SUM_W-1:0]   sum_ff;

   // A stage takes new data when it is empty or its content moves on.
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Neighbours in mask bit order.
   assign nb[0] = in_item.west_value;
   assign nb[1] = in_item.east_value;
   assign nb[2] = in_item.south_value;
   assign nb[3] = in_item.north_value;
   assign nb[4] = in_item.below_value;
   assign nb[5] = in_item.above_value;

   // Stage 1: masked differences and the source window test.
   always_comb begin
      for (int i = 0; i < NB_COUNT; i++) begin
         diff_in[i] = in_item.neighbour_mask[i]
                    ? DIFF_W'(nb[i]) - DIFF_W'(in_item.centre_value)
                    : '0;
      end
      src_in = in_item.cornified && (in_item.cell_age > win_low)
            && (in_item.cell_age <= win_high);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < NB_COUNT; i++) diff_ff[i] <= diff_in[i];
         c1_ff   <= in_item.centre_value;
         src1_ff <= src_in;
      end
   end

   // Stage 2: pairwise sums.
   always_comb begin
      for (int j = 0; j < NB_COUNT / 2; j++) begin
         pair_in[j] = PAIR_W'(diff_ff[2*j]) + PAIR_W'(diff_ff[2*j+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int j = 0; j < NB_COUNT / 2; j++) pair_ff[j] <= pair_in[j];
         c2_ff   <= c1_ff;
         src2_ff <= src1_ff;
      end
   end

   // Stage 3: full sum.
   assign sum_in = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]) + SUM_W'(pair_ff[2]);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sum_ff  <= sum_in;
         c3_ff   <= c2_ff;
         src3_ff <= src2_ff;
      end
   end

   assign out_valid       = valid_ff[STAGES-1];
   assign out_data.sum    = sum_ff;
   assign out_data.centre = c3_ff;
   assign out_data.src    = src3_ff;

endmodule

`default_nettype wire

>>> rtl/mdcu_qmul.sv
// ----------------------------------------------------------------------------
// Masked diffusion cell update: pipelined fixed-point multiplier
// Five stages: magnitude, low partial product, high partial product,
// recombine with scaling shift and clip, restore sign. Side data rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module mdcu_qmul import mdcu_pkg::*; #(
   parameter int IN_W      = 36,
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic signed [IN_W-1:0]   in_value,
   input  wire logic [SIDE_W-1:0]        in_side,
   input  wire logic [COEF_W-1:0]        coef,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic signed [STAGE_W-1:0]     out_value,
   output logic                          out_clip,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int STAGES  = 5;
   localparam int HI_W    = IN_W - LO_W;
   localparam int LP_W    = LO_W + COEF_W;
   localparam int HP_W    = HI_W + COEF_W;
   localparam int PROD_W  = IN_W + COEF_W;
   localparam int TOP_BIT = MAG_W + FRAC_BITS;   // products at or above clip
   localparam int EXT_W   = (PROD_W > TOP_BIT) ? PROD_W : TOP_BIT + 1;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;

   logic [IN_W-1:0]           val_u;
   logic [IN_W-1:0]           mag_in;
   logic [IN_W-1:0]           mag_ff;
   logic [LP_W-1:0]           lp_in;
   logic [LP_W-1:0]           lp2_ff, lp3_ff;
   logic [HI_W-1:0]           hi_ff;
   logic [HP_W-1:0]           hp_in;
   logic [HP_W-1:0]           hp_ff;
   logic [EXT_W-1:0]          prod;
   logic                      clip_in;
   logic [MAG_W-1:0]          r_in;
   logic [MAG_W-1:0]          r_ff;
   logic                      clip4_ff, clip5_ff;
   logic [STAGE_W-1:0]        r_ext;
   logic signed [STAGE_W-1:0] res_in;
   logic signed [STAGE_W-1:0] res_ff;
   logic                      neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [SIDE_W-1:0]         side_ff [STAGES];

   // A stage takes new data when it is empty or its content moves on.
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Side data follows its item through every stage.
   always_ff @(posedge clock) begin
      if (adv[0]) side_ff[0] <= in_side;
      for (int k = 1; k < STAGES; k++) begin
         if (adv[k]) side_ff[k] <= side_ff[k-1];
      end
   end

   // Stage 1: magnitude and sign.
   assign val_u  = in_value;
   assign mag_in = val_u[IN_W-1] ? IN_W'(0) - val_u : val_u;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mag_ff  <= mag_in;
         neg1_ff <= val_u[IN_W-1];
      end
   end

   // Stage 2: low slice times coefficient.
   assign lp_in = LP_W'(mag_ff[LO_W-1:0]) * LP_W'(coef);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         lp2_ff  <= lp_in;
         hi_ff   <= mag_ff[IN_W-1:LO_W];
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: high slice times coefficient.
   assign hp_in = HP_W'(hi_ff) * HP_W'(coef);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         hp_ff   <= hp_in;
         lp3_ff  <= lp2_ff;
         neg3_ff <= neg2_ff;
      end
   end

   // Stage 4: recombine, drop the fraction bits and clip the magnitude.
   always_comb begin
      prod    = (EXT_W'(hp_ff) << LO_W) + EXT_W'(lp3_ff);
      clip_in = |prod[EXT_W-1:TOP_BIT];
      r_in    = clip_in ? {MAG_W{1'b1}} : prod[TOP_BIT-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         r_ff     <= r_in;
         clip4_ff <= clip_in;
         neg4_ff  <= neg3_ff;
      end
   end

   // Stage 5: restore the sign; truncation is toward zero.
   assign r_ext  = STAGE_W'(r_ff);
   assign res_in = neg4_ff ? STAGE_W'(0) - r_ext : r_ext;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         res_ff   <= res_in;
         clip5_ff <= clip4_ff;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_value = res_ff;
   assign out_clip  = clip5_ff;
   assign out_side  = side_ff[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/masked_diffusion_cell_update.sv
// ----------------------------------------------------------------------------
// Masked diffusion cell update
// One explicit Euler reaction-diffusion update of a grid cell per item,
// in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one cell: centre and six neighbour values, the neighbour
//   mask, the cornified flag and the cell age. rsp_bus returns the updated
//   value and a flag that is set when any intermediate or final clip hit.
//   csr_bus writes the six coefficient and window registers; it is always
//   ready and should be used only while no cell is in flight.
//   The block is a 25 stage pipeline: front end (3), decay multiply (5),
//   two diffusion multiplies (5 each), rate sum (1), time step multiply (5)
//   and the final add with saturation (1), whose register drives rsp_bus.
//   One cell is accepted every cycle while rsp_bus is ready. Each multiplier
//   splits its operand into two slices of at most 32 bits and forms the
//   partial products in separate stages.
//   When rsp_bus stalls, each stage holds its item and empty stages keep
//   filling, so req_bus stays ready until the pipeline is full.
//   Reset empties the pipeline and loads the registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_diffusion_cell_update import mdcu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   mdcu_req_if.sink     req_bus,
   mdcu_rsp_if.source   rsp_bus,
   mdcu_csr_if.sink     csr_bus
);

   localparam int RATE_W = STAGE_W + 2;
   localparam int NV_W   = STAGE_W + 1;
   localparam logic signed [RATE_W-1:0] RATE_MAX = RATE_W'(STAGE_MAX);
   localparam logic signed [RATE_W-1:0] RATE_MIN = -RATE_MAX;
   localparam logic signed [NV_W-1:0]   NV_MAX   = NV_W'(32'sh7FFF_FFFF);
   localparam logic signed [NV_W-1:0]   NV_MIN   = NV_W'(32'sh8000_0000);

   // Configuration registers.
   logic [COEF_W-1:0]         step_time_ff;
   logic [COEF_W-1:0]         diffusion_coeff_ff;
   logic [COEF_W-1:0]         inv_spacing_sq_ff;
   logic [COEF_W-1:0]         decay_rate_ff;
   logic signed [VALUE_W-1:0] window_low_ff;
   logic signed [VALUE_W-1:0] window_high_ff;

   item_type                  item;
   logic                      front_valid, front_ready;
   front_type                 front_data;
   logic signed [VALUE_W:0]   centre_ext;

   logic                      mula_valid, mula_ready, mula_clip;
   logic signed [STAGE_W-1:0] mula_value;
   front_type                 mula_side;
   diff_side_type             mulb_side_in;

   logic                      mulb_valid, mulb_ready, mulb_clip;
   logic signed [STAGE_W-1:0] mulb_value;
   diff_side_type             mulb_side;
   diff_side_type             mulc_side_in;

   logic                      mulc_valid, mulc_ready, mulc_clip;
   logic signed [STAGE_W-1:0] mulc_value;
   diff_side_type             mulc_side;

   logic                      rate_adv;
   logic                      rate_valid_ff;
   logic signed [RATE_W-1:0]  rate_sum;
   logic signed [STAGE_W-1:0] rate_in;
   logic                      rate_clip_in;
   logic signed [STAGE_W-1:0] rate_ff;
   step_side_type             rate_side_ff;

   logic                      muld_ready, muld_valid, muld_clip;
   logic signed [STAGE_W-1:0] muld_value;
   step_side_type             muld_side;

   logic                      fin_adv;
   logic                      fin_valid_ff;
   logic signed [NV_W-1:0]    nv_sum;
   logic signed [VALUE_W-1:0] nv_in;
   logic                      sat_in;
   logic signed [VALUE_W-1:0] nv_ff;
   logic                      sat_ff;

   // Register writes; indexes past the last register are dropped.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff       <= STEP_TIME_RST;
         diffusion_coeff_ff <= DIFFUSION_COEFF_RST;
         inv_spacing_sq_ff  <= INV_SPACING_SQ_RST;
         decay_rate_ff      <= DECAY_RATE_RST;
         window_low_ff      <= WINDOW_LOW_RST;
         window_high_ff     <= WINDOW_HIGH_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_STEP_TIME:       step_time_ff       <= csr_bus.data[COEF_W-1:0];
            CSR_DIFFUSION_COEFF: diffusion_coeff_ff <= csr_bus.data[COEF_W-1:0];
            CSR_INV_SPACING_SQ:  inv_spacing_sq_ff  <= csr_bus.data[COEF_W-1:0];
            CSR_DECAY_RATE:      decay_rate_ff      <= csr_bus.data[COEF_W-1:0];
            CSR_WINDOW_LOW:      window_low_ff      <= csr_bus.data;
            CSR_WINDOW_HIGH:     window_high_ff     <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   // Gather the request payload.
   assign item.centre_value   = req_bus.centre_value;
   assign item.west_value     = req_bus.west_value;
   assign item.east_value     = req_bus.east_value;
   assign item.south_value    = req_bus.south_value;
   assign item.north_value    = req_bus.north_value;
   assign item.below_value    = req_bus.below_value;
   assign item.above_value    = req_bus.above_value;
   assign item.neighbour_mask = req_bus.neighbour_mask;
   assign item.cornified      = req_bus.cornified;
   assign item.cell_age       = req_bus.cell_age;

   // Laplacian sum and source window.
   mdcu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_item   (item),
      .win_low   (window_low_ff),
      .win_high  (window_high_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // Decay term: centre times decay rate.
   assign centre_ext = (VALUE_W + 1)'(front_data.centre);

   mdcu_qmul #(
      .IN_W      (VALUE_W + 1),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(front_type))
   ) u_mul_decay (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_value  (centre_ext),
      .in_side   (front_data),
      .coef      (decay_rate_ff),
      .out_valid (mula_valid),
      .out_ready (mula_ready),
      .out_value (mula_value),
      .out_clip  (mula_clip),
      .out_side  (mula_side)
   );

   // Diffusion term, first factor: sum times diffusion coefficient.
   assign mulb_side_in.decay  = mula_value;
   assign mulb_side_in.centre = mula_side.centre;
   assign mulb_side_in.src    = mula_side.src;
   assign mulb_side_in.clip   = mula_clip;

   mdcu_qmul #(
      .IN_W      (SUM_W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(diff_side_type))
   ) u_mul_coeff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mula_valid),
      .in_ready  (mula_ready),
      .in_value  (mula_side.sum),
      .in_side   (mulb_side_in),
      .coef      (diffusion_coeff_ff),
      .out_valid (mulb_valid),
      .out_ready (mulb_ready),
      .out_value (mulb_value),
      .out_clip  (mulb_clip),
      .out_side  (mulb_side)
   );

   // Diffusion term, second factor: inverse spacing squared.
   assign mulc_side_in.decay  = mulb_side.decay;
   assign mulc_side_in.centre = mulb_side.centre;
   assign mulc_side_in.src    = mulb_side.src;
   assign mulc_side_in.clip   = mulb_side.clip | mulb_clip;

   mdcu_qmul #(
      .IN_W      (STAGE_W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(diff_side_type))
   ) u_mul_spacing (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mulb_valid),
      .in_ready  (mulb_ready),
      .in_value  (mulb_value),
      .in_side   (mulc_side_in),
      .coef      (inv_spacing_sq_ff),
      .out_valid (mulc_valid),
      .out_ready (mulc_ready),
      .out_value (mulc_value),
      .out_clip  (mulc_clip),
      .out_side  (mulc_side)
   );

   // Rate: diffusion minus decay plus source, clipped to the stage range.
   always_comb begin
      rate_sum = RATE_W'(mulc_value) - RATE_W'(mulc_side.decay)
               + (mulc_side.src ? (RATE_W'(1) << FRAC_BITS) : RATE_W'(0));
      rate_clip_in = 1'b0;
      priority if (rate_sum > RATE_MAX) begin
         rate_in      = STAGE_MAX;
         rate_clip_in = 1'b1;
      end else if (rate_sum < RATE_MIN) begin
         rate_in      = -STAGE_MAX;
         rate_clip_in = 1'b1;
      end else begin
         rate_in = rate_sum[STAGE_W-1:0];
      end
   end

   assign rate_adv   = !rate_valid_ff || muld_ready;
   assign mulc_ready = rate_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_valid_ff <= 1'b0;
      end else if (rate_adv) begin
         rate_valid_ff <= mulc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rate_adv) begin
         rate_ff             <= rate_in;
         rate_side_ff.centre <= mulc_side.centre;
         rate_side_ff.clip   <= mulc_side.clip | mulc_clip | rate_clip_in;
      end
   end

   // Step: rate times time step.
   mdcu_qmul #(
      .IN_W      (STAGE_W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(step_side_type))
   ) u_mul_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rate_valid_ff),
      .in_ready  (muld_ready),
      .in_value  (rate_ff),
      .in_side   (rate_side_ff),
      .coef      (step_time_ff),
      .out_valid (muld_valid),
      .out_ready (fin_adv),
      .out_value (muld_value),
      .out_clip  (muld_clip),
      .out_side  (muld_side)
   );

   // New value: centre plus step, saturated to the output range.
   always_comb begin
      nv_sum = NV_W'(muld_value) + NV_W'(muld_side.centre);
      sat_in = muld_side.clip | muld_clip;
      priority if (nv_sum > NV_MAX) begin
         nv_in  = NV_MAX[VALUE_W-1:0];
         sat_in = 1'b1;
      end else if (nv_sum < NV_MIN) begin
         nv_in  = NV_MIN[VALUE_W-1:0];
         sat_in = 1'b1;
      end else begin
         nv_in = nv_sum[VALUE_W-1:0];
      end
   end

   // Output register; it holds while the receiver stalls.
   assign fin_adv = !fin_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (fin_adv) begin
         fin_valid_ff <= muld_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_adv) begin
         nv_ff  <= nv_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_bus.valid     = fin_valid_ff;
   assign rsp_bus.new_value = nv_ff;
   assign rsp_bus.saturated = sat_ff;

endmodule

`default_nettype wire

>>> test/masked_diffusion_cell_update_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked diffusion cell update: testbench
// Streams cell items into the block through a clocked driver and checks every
// updated concentration and its clip flag against a fixed-point predictor in
// this file. The run steps through several register settings, from all zero
// to full scale. Both channels idle at random, and the result side holds off
// once for a long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------

module masked_diffusion_cell_update_tb;
   import mdcu_pkg::*;

   localparam int FRAC_BITS     = 16;
   localparam int NB_TOTAL      = 6;
   localparam int MAX_WAIT      = 18;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_CELLS   = 330;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int MAX_REPORTS   = 40;

   // Register indexes that the block must ignore.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_7 = 3'd7;

   localparam logic signed [VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] ONE_Q     = 32'sd1 <<< FRAC_BITS;

   typedef logic signed [71:0] wide_type;
   localparam wide_type STAGE_LIMIT = 72'sh3FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [VALUE_W-1:0] new_value;
      logic                      saturated;
   } cell_result_type;

   logic clock;
   logic reset;

   mdcu_req_if req_bus ();
   mdcu_rsp_if rsp_bus ();
   mdcu_csr_if csr_bus ();

   masked_diffusion_cell_update #(.FRAC_BITS(FRAC_BITS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Copy of the register file as the block should hold it.
   logic [COEF_W-1:0]         dt_reg;
   logic [COEF_W-1:0]         diffusion_reg;
   logic [COEF_W-1:0]         inv_spacing_reg;
   logic [COEF_W-1:0]         decay_reg;
   logic signed [VALUE_W-1:0] window_low_reg;
   logic signed [VALUE_W-1:0] window_high_reg;

   item_type        cells_to_send[$];
   cell_result_type awaited_updates[$];
   item_type        cell_on_bus;

   bit send_idle;
   bit sink_idle;
   int hold_requests;
   int hold_served;
   int send_wait;
   int sink_wait;
   int hold_left;
   int cycle_count;
   int mismatch_count;
   int result_count;

   always #2 clock = ~clock;

   // Product of a signed stage value and a coefficient, shifted down toward
   // zero and clipped to the symmetric stage range.
   function automatic wide_type scale_fixed(input wide_type operand,
                                            input logic [COEF_W-1:0] coef,
                                            inout logic clipped);
      logic [127:0] magnitude;
      logic [127:0] scaled;
      magnitude = (operand < 0) ? -operand : operand;
      scaled = (magnitude * coef) >> FRAC_BITS;
      if (scaled > STAGE_LIMIT) begin
         scaled = STAGE_LIMIT;
         clipped = 1'b1;
      end
      return (operand < 0) ? -wide_type'(scaled) : wide_type'(scaled);
   endfunction

   // Explicit Euler update of one cell under the current register settings.
   function automatic cell_result_type cell_update(input item_type site);
      logic signed [VALUE_W-1:0] nb [NB_TOTAL];
      wide_type centre, nb_sum, partial, diffusion, decay, rate, step, updated;
      logic clipped;
      cell_result_type result;
      nb[0] = site.west_value;
      nb[1] = site.east_value;
      nb[2] = site.south_value;
      nb[3] = site.north_value;
      nb[4] = site.below_value;
      nb[5] = site.above_value;
      centre = $signed(site.centre_value);
      clipped = 1'b0;
      nb_sum = 0;
      for (int k = 0; k < NB_TOTAL; k++) begin
         if (site.neighbour_mask[k]) nb_sum = nb_sum + nb[k] - centre;
      end

      partial = scale_fixed(nb_sum, diffusion_reg, clipped);
      diffusion = scale_fixed(partial, inv_spacing_reg, clipped);
      decay = scale_fixed(centre, decay_reg, clipped);
      rate = diffusion - decay;
      // Source term: only cornified cells whose age lies in (low, high].
      if (site.cornified && $signed(site.cell_age) > window_low_reg &&
          $signed(site.cell_age) <= window_high_reg) begin
         rate = rate + ONE_Q;
      end
      if (rate > STAGE_LIMIT) begin
         rate = STAGE_LIMIT;
         clipped = 1'b1;
      end else if (rate < -STAGE_LIMIT) begin
         rate = -STAGE_LIMIT;
         clipped = 1'b1;
      end

      step = scale_fixed(rate, dt_reg, clipped);
      updated = centre + step;
      if (updated > wide_type'(MAX_VALUE)) begin
         updated = MAX_VALUE;
         clipped = 1'b1;
      end else if (updated < wide_type'(MIN_VALUE)) begin
         updated = MIN_VALUE;
         clipped = 1'b1;
      end
      result.new_value = updated[VALUE_W-1:0];
      result.saturated = clipped;
      return result;
   endfunction

   // Mostly values near the anchor, with full-range and extreme values mixed in.
   function automatic logic signed [VALUE_W-1:0] pick_value(
         input logic signed [VALUE_W-1:0] anchor);
      logic signed [VALUE_W-1:0] value;
      case ($urandom_range(0, 9))
         0: value = $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: value = MIN_VALUE;
               1: value = MAX_VALUE;
               2: value = 0;
               default: value = -1;
            endcase
         end
         default: value = anchor + $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      endcase
      return value;
   endfunction

   function automatic item_type random_cell();
      item_type site;
      site.centre_value   = pick_value(32'sd0);
      site.west_value     = pick_value(site.centre_value);
      site.east_value     = pick_value(site.centre_value);
      site.south_value    = pick_value(site.centre_value);
      site.north_value    = pick_value(site.centre_value);
      site.below_value    = pick_value(site.centre_value);
      site.above_value    = pick_value(site.centre_value);
      site.neighbour_mask = MASK_W'($urandom_range(0, 63));
      site.cornified      = ($urandom_range(0, 3) != 0);
      // Ages cluster around both window bounds to hit the edges often.
      case ($urandom_range(0, 2))
         0: site.cell_age = $urandom;
         1: site.cell_age = window_low_reg + $signed($urandom_range(0, 4)) - 2;
         default: site.cell_age = window_high_reg + $signed($urandom_range(0, 4)) - 2;
      endcase
      return site;
   endfunction

   function automatic item_type make_cell(input logic signed [VALUE_W-1:0] centre,
                                          input logic signed [VALUE_W-1:0] around,
                                          input logic [MASK_W-1:0] mask,
                                          input logic corn,
                                          input logic signed [VALUE_W-1:0] age);
      item_type site;
      site.centre_value   = centre;
      site.west_value     = around;
      site.east_value     = around;
      site.south_value    = around;
      site.north_value    = around;
      site.below_value    = around;
      site.above_value    = around;
      site.neighbour_mask = mask;
      site.cornified      = corn;
      site.cell_age       = age;
      return site;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // One register write; waits for the transfer on the register channel.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] dt, db, idz2, kb,
                                wlow, whigh);
      write_reg(CSR_STEP_TIME, dt);
      write_reg(CSR_DIFFUSION_COEFF, db);
      write_reg(CSR_INV_SPACING_SQ, idz2);
      write_reg(CSR_DECAY_RATE, kb);
      write_reg(CSR_WINDOW_LOW, wlow);
      write_reg(CSR_WINDOW_HIGH, whigh);
   endtask

   // Returns once every queued cell has been taken and every result checked.
   task automatic wait_idle();
      while (cells_to_send.size() != 0 || req_bus.valid || awaited_updates.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_cells(input int count, input bit idle_in, input bit idle_out,
                            input bit long_stall);
      @(negedge clock);
      send_idle = idle_in;
      sink_idle = idle_out;
      for (int k = 0; k < count; k++) cells_to_send.push_back(random_cell());
      if (long_stall) hold_requests++;
      wait_idle();
   endtask

   task automatic moderate_setting();
      logic [CSR_DATA_W-1:0] wlow;
      wlow = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      apply_setting($urandom_range(0, 32'h0001_0000), $urandom_range(0, 32'h0004_0000),
                    $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0002_0000),
                    wlow, wlow + $urandom_range(0, 32'h0040_0000));
   endtask

   // Track register writes as the block should see them.
   always @(posedge clock) begin
      if (reset) begin
         dt_reg          <= 31'd65;
         diffusion_reg   <= 31'd65536;
         inv_spacing_reg <= 31'd65536;
         decay_reg       <= 31'd0;
         window_low_reg  <= 32'sd0;
         window_high_reg <= 32'sd0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_STEP_TIME:       dt_reg          <= csr_bus.data[COEF_W-1:0];
            CSR_DIFFUSION_COEFF: diffusion_reg   <= csr_bus.data[COEF_W-1:0];
            CSR_INV_SPACING_SQ:  inv_spacing_reg <= csr_bus.data[COEF_W-1:0];
            CSR_DECAY_RATE:      decay_reg       <= csr_bus.data[COEF_W-1:0];
            CSR_WINDOW_LOW:      window_low_reg  <= csr_bus.data;
            CSR_WINDOW_HIGH:     window_high_reg <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Cell driver: predicts each accepted cell, then offers the next one after
   // a random gap when send_idle is set.
   always @(posedge clock) begin : cell_driver
      logic holding;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_wait = 0;
      end else begin
         holding = req_bus.valid && !req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            awaited_updates.push_back(cell_update(cell_on_bus));
            send_wait = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (!holding) begin
            if (send_wait > 0) begin
               send_wait--;
               req_bus.valid <= 1'b0;
            end else if (cells_to_send.size() != 0) begin
               cell_on_bus = cells_to_send.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.centre_value   <= cell_on_bus.centre_value;
               req_bus.west_value     <= cell_on_bus.west_value;
               req_bus.east_value     <= cell_on_bus.east_value;
               req_bus.south_value    <= cell_on_bus.south_value;
               req_bus.north_value    <= cell_on_bus.north_value;
               req_bus.below_value    <= cell_on_bus.below_value;
               req_bus.above_value    <= cell_on_bus.above_value;
               req_bus.neighbour_mask <= cell_on_bus.neighbour_mask;
               req_bus.cornified      <= cell_on_bus.cornified;
               req_bus.cell_age       <= cell_on_bus.cell_age;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transfer against the oldest prediction and
   // stalls the result channel at random or for a long requested stretch.
   always @(posedge clock) begin : result_monitor
      cell_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (awaited_updates.size() == 0) begin
               report_mismatch($sformatf("result %0d with no cell pending, new_value %0d",
                                         result_count, rsp_bus.new_value));
            end else begin
               want = awaited_updates.pop_front();
               if (rsp_bus.new_value !== want.new_value)
                  report_mismatch($sformatf("result %0d new_value %0d, predicted %0d",
                                            result_count, rsp_bus.new_value,
                                            want.new_value));
               if (rsp_bus.saturated !== want.saturated)
                  report_mismatch($sformatf("result %0d saturated %0b, predicted %0b",
                                            result_count, rsp_bus.saturated,
                                            want.saturated));
            end
            sink_wait = sink_idle ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (hold_served < hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (sink_wait > 0) begin
            sink_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      item_type site;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.centre_value   = '0;
      req_bus.west_value     = '0;
      req_bus.east_value     = '0;
      req_bus.south_value    = '0;
      req_bus.north_value    = '0;
      req_bus.below_value    = '0;
      req_bus.above_value    = '0;
      req_bus.neighbour_mask = '0;
      req_bus.cornified      = 1'b0;
      req_bus.cell_age       = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = '0;
      csr_bus.data           = '0;
      send_idle = 1'b1;
      sink_idle = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: tiny step and an empty age window.
      @(negedge clock);
      cells_to_send.push_back(make_cell(0, 0, 6'd0, 1'b0, 0));
      cells_to_send.push_back(make_cell(MAX_VALUE, MIN_VALUE, 6'h3F, 1'b0, 0));
      cells_to_send.push_back(make_cell(MIN_VALUE, MAX_VALUE, 6'h3F, 1'b1, MAX_VALUE));
      cells_to_send.push_back(make_cell(MAX_VALUE, MAX_VALUE, 6'h3F, 1'b1, 0));
      // One neighbour at a time, each with its own value, to pin the mask order.
      for (int k = 0; k < NB_TOTAL; k++) begin
         site = make_cell(ONE_Q, 0, 6'd1 << k, 1'b0, 0);
         site.west_value  = 32'sh0002_0000;
         site.east_value  = 32'sh0003_0000;
         site.south_value = 32'sh0005_0000;
         site.north_value = 32'sh0009_0000;
         site.below_value = 32'sh0011_0000;
         site.above_value = 32'sh0021_0000;
         cells_to_send.push_back(site);
      end
      wait_idle();

      // Unit step with a window of (-1, 2]; writes to unused indexes must
      // leave every register alone.
      apply_setting(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'h0000_4000,
                    -ONE_Q, 2 * ONE_Q);
      write_reg(CSR_UNUSED_6, $urandom);
      write_reg(CSR_UNUSED_7, $urandom);
      @(negedge clock);
      cells_to_send.push_back(make_cell(ONE_Q, 0, 6'h3F, 1'b1, -ONE_Q));
      cells_to_send.push_back(make_cell(ONE_Q, 0, 6'h3F, 1'b1, -ONE_Q + 1));
      cells_to_send.push_back(make_cell(ONE_Q, 0, 6'h3F, 1'b1, 2 * ONE_Q));
      cells_to_send.push_back(make_cell(ONE_Q, 0, 6'h3F, 1'b1, 2 * ONE_Q + 1));
      // Age inside the window but the cell is not cornified.
      cells_to_send.push_back(make_cell(ONE_Q, 0, 6'h3F, 1'b0, 0));
      cells_to_send.push_back(make_cell(MAX_VALUE, MIN_VALUE, 6'h3F, 1'b1, 0));
      cells_to_send.push_back(make_cell(MIN_VALUE, MAX_VALUE, 6'h3F, 1'b0, 0));
      wait_idle();

      // Zero step with full-scale coefficients: a clip inside the diffusion
      // term still flags the result although the value stays put.
      apply_setting(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    -ONE_Q, 2 * ONE_Q);
      @(negedge clock);
      cells_to_send.push_back(make_cell(MAX_VALUE, MIN_VALUE, 6'h3F, 1'b1, ONE_Q));
      cells_to_send.push_back(make_cell(0, 0, 6'h3F, 1'b0, 0));
      cells_to_send.push_back(make_cell(MIN_VALUE, MAX_VALUE, 6'h3F, 1'b1, 0));
      cells_to_send.push_back(make_cell(MAX_VALUE, 0, 6'd0, 1'b0, 0));
      wait_idle();

      // Random cells under a sequence of settings.
      moderate_setting();
      run_cells(PHASE_CELLS, 1'b1, 1'b1, 1'b0);

      // No idling, with one long hold-off on the result side.
      moderate_setting();
      run_cells(PHASE_CELLS, 1'b0, 1'b0, 1'b1);

      // Full scale; the top data bit of each coefficient write is dropped.
      apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    MIN_VALUE, MAX_VALUE);
      run_cells(PHASE_CELLS, 1'b1, 1'b0, 1'b0);

      // All coefficients zero and a reversed, hence empty, window.
      apply_setting(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                    MAX_VALUE, MIN_VALUE);
      run_cells(PHASE_CELLS, 1'b0, 1'b1, 1'b0);

      apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_cells(PHASE_CELLS, 1'b1, 1'b1, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
